### hw/rtl/pesev_pkg.sv
// Shared types and constants for the prefix expression stack evaluator.
// Token codes, operator and error codes, and the request/response structs of the arithmetic unit.
`timescale 1ns / 1ps
package pesev_pkg;

	localparam logic [7:0] TOK_MUL = 8'h2A;
	localparam logic [7:0] TOK_DIV = 8'h2F;
	localparam logic [7:0] TOK_ADD = 8'h2B;
	localparam logic [7:0] TOK_SUB = 8'h2D;
	localparam logic [7:0] TOK_MOD = 8'h25;
	localparam logic [7:0] TOK_POW = 8'h5E;
	localparam logic [7:0] TOK_NEG = 8'h21;
	localparam logic [7:0] TOK_A   = 8'h61;
	localparam logic [7:0] TOK_Z   = 8'h7A;
	localparam int unsigned NUM_VARS = 26;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK,
		ERR_UNDERFLOW,
		ERR_DIV_ZERO,
		ERR_FULL,
		ERR_ZERO_NEG_POW
	} err_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		err_t err;
	} alu_rsp_t;

	function automatic op_t tok_to_op(input logic [7:0] tok);
		op_t op;
		case (tok)
			TOK_MUL: op = OP_MUL;
			TOK_DIV: op = OP_DIV;
			TOK_SUB: op = OP_SUB;
			TOK_MOD: op = OP_MOD;
			TOK_POW: op = OP_POW;
			default: op = OP_ADD;
		endcase
		return op;
	endfunction

endpackage

### hw/rtl/pesev_alu.sv
// Shared multi-cycle arithmetic unit: add, subtract, shift-add multiply,
// restoring divide/modulo and square-and-multiply power. Depends on pesev_pkg.
`timescale 1ns / 1ps
module pesev_alu #(
	parameter int unsigned W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pesev_pkg::alu_req_t req,
	input  logic [W-1:0]        a,
	input  logic [W-1:0]        b,
	output pesev_pkg::alu_rsp_t rsp,
	output logic [W-1:0]        res
);
	import pesev_pkg::*;

	localparam int unsigned CW = $clog2(W + 1);
	localparam logic [W-1:0] ONE = W'(1);

	typedef enum logic [2:0] {
		A_IDLE,
		A_MUL,
		A_DIV,
		A_PCHK,
		A_PMR,
		A_PSQ
	} astate_t;

	astate_t       state_q;
	op_t           op_q;
	logic [W-1:0]  acc_q, cand_q, plier_q;
	logic [W-1:0]  rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          sa_q, sb_q;
	logic [W-1:0]  r_q, base_q, e_q;
	alu_rsp_t      rsp_q;
	logic [W-1:0]  res_q;

	logic [W:0]    rem_sh, rem_try;
	logic [W-1:0]  acc_add, abs_a, abs_b;

	assign rem_sh  = {rem_q, quo_q[W-1]};
	assign rem_try = rem_sh - {1'b0, dvs_q};
	assign acc_add = acc_q + cand_q;
	assign abs_a   = a[W-1] ? (W'(0) - a) : a;
	assign abs_b   = b[W-1] ? (W'(0) - b) : b;
	assign rsp     = rsp_q;
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		alu_rsp_t rsp_n;
		if (!arst_n) begin
			state_q <= A_IDLE;
			rsp_q   <= '{done: 1'b0, err: ERR_OK};
		end else begin
			rsp_n      = rsp_q;
			rsp_n.done = 1'b0;
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q      <= req.op;
						rsp_n.err = ERR_OK;
						case (req.op)
							OP_ADD: begin
								res_q      <= a + b;
								rsp_n.done = 1'b1;
							end
							OP_SUB: begin
								res_q      <= a - b;
								rsp_n.done = 1'b1;
							end
							OP_MUL: begin
								acc_q   <= '0;
								cand_q  <= a;
								plier_q <= b;
								state_q <= A_MUL;
							end
							OP_DIV, OP_MOD: begin
								if (b == '0) begin
									rsp_n.err  = ERR_DIV_ZERO;
									rsp_n.done = 1'b1;
								end else begin
									sa_q    <= a[W-1];
									sb_q    <= b[W-1];
									quo_q   <= abs_a;
									dvs_q   <= abs_b;
									rem_q   <= '0;
									cnt_q   <= '0;
									state_q <= A_DIV;
								end
							end
							OP_POW: begin
								if (b[W-1]) begin
									rsp_n.done = 1'b1;
									if (a == '0)
										rsp_n.err = ERR_ZERO_NEG_POW;
									else if (a == ONE)
										res_q <= ONE;
									else if (a == '1)
										res_q <= b[0] ? '1 : ONE;
									else
										res_q <= '0;
								end else begin
									r_q     <= ONE;
									base_q  <= a;
									e_q     <= b;
									state_q <= A_PCHK;
								end
							end
							default: begin
								res_q      <= '0;
								rsp_n.done = 1'b1;
							end
						endcase
					end
				end
				A_MUL, A_PMR, A_PSQ: begin
					if (plier_q != '0) begin
						if (plier_q[0])
							acc_q <= acc_add;
						cand_q  <= cand_q << 1;
						plier_q <= plier_q >> 1;
					end else begin
						case (state_q)
							A_MUL: begin
								res_q      <= acc_q;
								rsp_n.done = 1'b1;
								state_q    <= A_IDLE;
							end
							A_PMR: begin
								r_q <= acc_q;
								if (e_q[W-1:1] == '0) begin
									res_q      <= acc_q;
									rsp_n.done = 1'b1;
									state_q    <= A_IDLE;
								end else begin
									acc_q   <= '0;
									cand_q  <= base_q;
									plier_q <= base_q;
									e_q     <= e_q >> 1;
									state_q <= A_PSQ;
								end
							end
							default: begin
								base_q  <= acc_q;
								state_q <= A_PCHK;
							end
						endcase
					end
				end
				A_PCHK: begin
					if (e_q == '0) begin
						res_q      <= r_q;
						rsp_n.done = 1'b1;
						state_q    <= A_IDLE;
					end else if (e_q[0]) begin
						acc_q   <= '0;
						cand_q  <= r_q;
						plier_q <= base_q;
						state_q <= A_PMR;
					end else begin
						acc_q   <= '0;
						cand_q  <= base_q;
						plier_q <= base_q;
						e_q     <= e_q >> 1;
						state_q <= A_PSQ;
					end
				end
				A_DIV: begin
					if (cnt_q == CW'(W)) begin
						if (op_q == OP_DIV)
							res_q <= (sa_q ^ sb_q) ? (W'(0) - quo_q) : quo_q;
						else
							res_q <= sa_q ? (W'(0) - rem_q) : rem_q;
						rsp_n.done = 1'b1;
						state_q    <= A_IDLE;
					end else begin
						rem_q <= rem_try[W] ? rem_sh[W-1:0] : rem_try[W-1:0];
						quo_q <= {quo_q[W-2:0], ~rem_try[W]};
						cnt_q <= cnt_q + CW'(1);
					end
				end
				default: state_q <= A_IDLE;
			endcase
			rsp_q <= rsp_n;
		end
	end

endmodule

### hw/rtl/prefix_expression_stack_evaluator_unit.sv
// Prefix expression evaluator: value stack and letter table in synchronous RAMs.
// One item at a time: an item goes from decode straight to the output register (new letter,
// '!' or other), through a letter-table read (known letter), or through the stack operand read
// and the bit-serial steps of pesev_alu (binary operators). The next item can be taken
// in the cycle after the result loads. Depends on pesev_pkg, pesev_alu.
// Reset empties the stack and forgets all letters; RAM contents are not cleared.
`timescale 1ns / 1ps
module prefix_expression_stack_evaluator_unit #(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         token,
	input  logic signed [31:0] var_value,
	input  logic               first_token,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] top_value,
	output logic [6:0]         stack_depth,
	output logic [2:0]         error_code
);
	import pesev_pkg::*;

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DEC,
		S_RDV,
		S_RDB,
		S_ALU,
		S_OUT
	} state_t;

	state_t                  state_q;
	logic [7:0]              tok_q;
	logic [W-1:0]            vv_q;
	logic [DW-1:0]           depth_q;
	logic [W-1:0]            top_q;
	logic [NUM_VARS-1:0]     known_q;
	err_t                    err_q;
	logic                    out_valid_q;
	logic signed [31:0]      top_value_q;
	logic [6:0]              stack_depth_q;
	logic [2:0]              error_code_q;

	logic [W-1:0]            stack_mem [STACK_DEPTH];
	logic [W-1:0]            var_mem [NUM_VARS];
	logic [W-1:0]            stk_rdata_q, var_rdata_q;

	logic                    stk_we, stk_re, var_we, var_re;
	logic [AW-1:0]           stk_waddr, stk_raddr;
	logic [W-1:0]            stk_wdata;
	logic [4:0]              var_idx;
	logic                    is_letter, is_binop, has_room;
	alu_req_t                alu_req;
	alu_rsp_t                alu_rsp;
	logic [W-1:0]            alu_res;

	always_comb begin
		is_letter = tok_q inside {[TOK_A:TOK_Z]};
		is_binop  = tok_q inside {TOK_MUL, TOK_DIV, TOK_ADD, TOK_SUB, TOK_MOD, TOK_POW};
	end
	assign var_idx  = 5'(tok_q - TOK_A);
	assign has_room = depth_q < DW'(STACK_DEPTH);
	assign in_ready = (state_q == S_IDLE);
	assign alu_req  = '{start: state_q == S_RDB, op: tok_to_op(tok_q)};

	always_comb begin
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		var_we    = 1'b0;
		var_re    = 1'b0;
		stk_waddr = AW'(depth_q);
		stk_raddr = AW'(depth_q - DW'(2));
		stk_wdata = vv_q;
		case (state_q)
			S_DEC: begin
				if (is_binop) begin
					stk_re = depth_q >= DW'(2);
				end else if (tok_q == TOK_NEG) begin
					stk_we    = depth_q != '0;
					stk_waddr = AW'(depth_q - DW'(1));
					stk_wdata = W'(0) - top_q;
				end else if (is_letter) begin
					if (known_q[var_idx]) begin
						var_re = 1'b1;
					end else begin
						var_we = 1'b1;
						stk_we = has_room;
					end
				end
			end
			S_RDV: begin
				stk_we    = has_room;
				stk_wdata = var_rdata_q;
			end
			S_ALU: begin
				stk_we    = alu_rsp.done && (alu_rsp.err == ERR_OK);
				stk_waddr = AW'(depth_q - DW'(2));
				stk_wdata = alu_res;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we)
			stack_mem[stk_waddr] <= stk_wdata;
		if (stk_re)
			stk_rdata_q <= stack_mem[stk_raddr];
		if (var_we)
			var_mem[var_idx] <= vv_q;
		if (var_re)
			var_rdata_q <= var_mem[var_idx];
	end

	pesev_alu #(.W(W)) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (top_q),
		.b      (stk_rdata_q),
		.rsp    (alu_rsp),
		.res    (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			known_q     <= '0;
			err_q       <= ERR_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						tok_q <= token;
						vv_q  <= W'(var_value);
						if (first_token) begin
							depth_q <= '0;
							known_q <= '0;
						end
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (is_binop) begin
						if (depth_q < DW'(2)) begin
							err_q   <= ERR_UNDERFLOW;
							state_q <= S_OUT;
						end else begin
							err_q   <= ERR_OK;
							state_q <= S_RDB;
						end
					end else if (tok_q == TOK_NEG) begin
						state_q <= S_OUT;
						if (depth_q == '0) begin
							err_q <= ERR_UNDERFLOW;
						end else begin
							err_q <= ERR_OK;
							top_q <= W'(0) - top_q;
						end
					end else if (is_letter) begin
						if (known_q[var_idx]) begin
							err_q   <= ERR_OK;
							state_q <= S_RDV;
						end else begin
							state_q          <= S_OUT;
							known_q[var_idx] <= 1'b1;
							if (has_room) begin
								err_q   <= ERR_OK;
								top_q   <= vv_q;
								depth_q <= depth_q + DW'(1);
							end else begin
								err_q <= ERR_FULL;
							end
						end
					end else begin
						err_q   <= ERR_OK;
						state_q <= S_OUT;
					end
				end
				S_RDV: begin
					if (has_room) begin
						top_q   <= var_rdata_q;
						depth_q <= depth_q + DW'(1);
					end else begin
						err_q <= ERR_FULL;
					end
					state_q <= S_OUT;
				end
				S_RDB: state_q <= S_ALU;
				S_ALU: begin
					if (alu_rsp.done) begin
						err_q <= alu_rsp.err;
						if (alu_rsp.err == ERR_OK) begin
							top_q   <= alu_res;
							depth_q <= depth_q - DW'(1);
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						top_value_q   <= (depth_q == '0) ? 32'sd0 : 32'(signed'(top_q));
						stack_depth_q <= 7'(depth_q);
						error_code_q  <= err_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign top_value   = top_value_q;
	assign stack_depth = stack_depth_q;
	assign error_code  = error_code_q;

endmodule

### hw/rtl/pesev_checker.sv
// Port-level checks for the prefix expression evaluator, bound to the top level.
// Depends on pesev_pkg and prefix_expression_stack_evaluator_unit.
`timescale 1ns / 1ps
module pesev_checker #(
	parameter int unsigned STACK_DEPTH = 64
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] top_value,
	input logic [6:0]         stack_depth,
	input logic [2:0]         error_code
);
	import pesev_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(error_code))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in flight");

	a_full_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code == ERR_FULL) |-> stack_depth == 7'(STACK_DEPTH))
		else $error("stack full reported below capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (STACK_DEPTH < 128) && (stack_depth == 7'd0) |-> top_value == 32'sd0)
		else $error("empty stack shows nonzero top");

	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_code <= 3'(ERR_ZERO_NEG_POW))
		else $error("error code out of range");

endmodule

bind prefix_expression_stack_evaluator_unit pesev_checker #(.STACK_DEPTH(STACK_DEPTH)) u_pesev_checker (.*);
